/* hw/rtl/bsl_pkg.sv */
// Shared codes and types for the bounded sequential list.
`default_nettype none

package bsl_pkg;

  // Operation codes; the codes above clear mean nothing and change nothing
  localparam logic [2:0] OP_GET    = 3'd0;
  localparam logic [2:0] OP_LOCATE = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPOS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic       load;   // copy slot into scan register
    logic       shift;  // scan register takes right neighbour's scan
    logic       ins;    // open a gap at pos and write elem there
    logic       del;    // close the gap at pos
    logic [4:0] pos;    // 1-based position
    logic [7:0] elem;
  } cell_cmd_t;

  // One result item
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] value;
    logic [4:0] found_at;
    logic [4:0] count;
    logic       is_empty;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/bsl_if.sv */
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface bsl_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [4:0] position;
  logic [7:0] element;

  modport source (output valid, output op, output position, output element, input ready);
  modport sink   (input valid, input op, input position, input element, output ready);
endinterface

interface bsl_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] value;
  logic [4:0] found_at;
  logic [4:0] count;
  logic       is_empty;

  modport source (output valid, output status, output value, output found_at,
                  output count, output is_empty, input ready);
  modport sink   (input valid, input status, input value, input found_at,
                  input count, input is_empty, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bounded_sequential_list.sv */
// Top level of the bounded sequential list: cell row, sequencer, result register.
`default_nettype none

// Ordered list of up to CAPACITY bytes held in a row of cells, one slot per
// cell. Insert and delete shift every cell of the row by one place at once,
// so insert, clear, unknown ops and any failed check give their result in the
// cycle after the request transfer. Get and delete at position p, and locate
// with its first match at position m, walk a snapshot of the row through the
// scan chain one cell per cycle toward cell 0, and a locate miss walks the
// whole list first. One request is worked on at a time; the next is taken
// once the current result is issued and the result register is free or
// being emptied. Slot contents are not cleared by reset or clear; only the
// length is.
module bounded_sequential_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire         clk,
  input  wire         rst,
  bsl_req_if.sink     req,
  bsl_rsp_if.source   rsp
);

  bsl_pkg::cell_cmd_t cmd;
  bsl_pkg::res_t      res;
  logic               res_valid;
  logic               out_free;
  logic [7:0]         slot [CAPACITY];
  logic [7:0]         scan [CAPACITY];
  logic               out_valid;
  bsl_pkg::res_t      out_r;

  assign out_free = !out_valid || rsp.ready;

  bsl_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .op        (req.op),
    .position  (req.position),
    .element   (req.element),
    .out_free  (out_free),
    .scan0     (scan[0]),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res       (res)
  );

  // Row of cells; the ends see zero neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [7:0] left_slot;
    logic [7:0] right_slot;
    logic [7:0] right_scan;
    if (i == 0) begin : g_first
      assign left_slot = 8'h00;
    end else begin : g_inner_l
      assign left_slot = slot[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_slot = 8'h00;
      assign right_scan = 8'h00;
    end else begin : g_inner_r
      assign right_slot = slot[i+1];
      assign right_scan = scan[i+1];
    end
    bsl_cell #(
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_slot  (left_slot),
      .right_slot (right_slot),
      .right_scan (right_scan),
      .slot       (slot[i]),
      .scan       (scan[i])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_r.status;
  assign rsp.value    = out_r.value;
  assign rsp.found_at = out_r.found_at;
  assign rsp.count    = out_r.count;
  assign rsp.is_empty = out_r.is_empty;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!out_valid || rsp.ready))
    else $error("result produced while output still held");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && !res_valid) |=> !req.ready)
    else $error("request taken while a scan is running");
`endif

endmodule

`default_nettype wire

/* hw/rtl/bsl_cell.sv */
// One list cell: a stored slot plus a scan register in the read-out chain.
`default_nettype none

module bsl_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                      clk,
  input  bsl_pkg::cell_cmd_t       cmd,
  input  wire  [7:0]               left_slot,
  input  wire  [7:0]               right_slot,
  input  wire  [7:0]               right_scan,
  output logic [7:0]               slot,
  output logic [7:0]               scan
);

  logic ins_here;
  logic ins_up;
  logic del_take;

  // Where this cell sits relative to the operation's position
  assign ins_here = cmd.ins && (32'(cmd.pos) == IDX + 1);
  assign ins_up   = cmd.ins && (32'(cmd.pos) <= IDX);
  assign del_take = cmd.del && (32'(cmd.pos) <= IDX + 1);

  // Slot: shift up on insert, down on delete
  always_ff @(posedge clk) begin
    priority if (ins_here) begin
      slot <= cmd.elem;
    end else if (ins_up) begin
      slot <= left_slot;
    end else if (del_take) begin
      slot <= right_slot;
    end
  end

  // Scan chain: snapshot, then march toward cell 0
  always_ff @(posedge clk) begin
    priority if (cmd.load) begin
      scan <= slot;
    end else if (cmd.shift) begin
      scan <= right_scan;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bsl_ctrl.sv */
// Sequencer: position checks, length, scan walk and result build.
`default_nettype none

module bsl_ctrl #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [2:0]            op,
  input  wire  [4:0]            position,
  input  wire  [7:0]            element,
  input  wire                   out_free,
  input  wire  [7:0]            scan0,
  output bsl_pkg::cell_cmd_t    cmd,
  output logic                  res_valid,
  output bsl_pkg::res_t         res
);

  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = ((FW > 5) ? FW : 5) + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [FW-1:0] fill, fill_next;
  logic [FW-1:0] k, k_next;
  logic [2:0]    op_r;
  logic [4:0]    pos_r;
  logic [7:0]    elem_r;
  logic          accept;
  logic [CW-1:0] fill_x;
  logic [CW-1:0] pos_x;
  logic [CW-1:0] k_x;
  logic          pos_ok_rd;
  logic          pos_ok_ins;

  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // Position checks against the current length
  assign fill_x     = CW'(fill);
  assign pos_x      = CW'(position);
  assign k_x        = CW'(k);
  assign pos_ok_rd  = (position != 5'd0) && (pos_x <= fill_x);
  assign pos_ok_ins = (position != 5'd0) && (pos_x <= fill_x + CW'(1));

  // Next state, cell command and result
  always_comb begin
    state_next   = state;
    fill_next    = fill;
    k_next       = k;
    res_valid    = 1'b0;
    res          = '0;
    res.status   = bsl_pkg::ST_OK;
    cmd          = '0;
    cmd.pos      = (state == S_IDLE) ? position : pos_r;
    cmd.elem     = (state == S_IDLE) ? element : elem_r;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            bsl_pkg::OP_GET, bsl_pkg::OP_DELETE: begin
              if (!pos_ok_rd) begin
                res_valid  = 1'b1;
                res.status = bsl_pkg::ST_BADPOS;
              end else begin
                cmd.load   = 1'b1;
                k_next     = '0;
                state_next = S_SCAN;
              end
            end
            bsl_pkg::OP_LOCATE: begin
              cmd.load   = 1'b1;
              k_next     = '0;
              state_next = S_SCAN;
            end
            bsl_pkg::OP_INSERT: begin
              res_valid = 1'b1;
              if (!pos_ok_ins) begin
                res.status = bsl_pkg::ST_BADPOS;
              end else if (fill_x == CW'(CAPACITY)) begin
                res.status = bsl_pkg::ST_FULL;
              end else begin
                cmd.ins   = 1'b1;
                fill_next = fill + FW'(1);
              end
            end
            bsl_pkg::OP_CLEAR: begin
              res_valid = 1'b1;
              fill_next = '0;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (op_r == bsl_pkg::OP_LOCATE) begin
          // Compare the head of the scan chain, one element a cycle
          if (k == fill) begin
            res_valid  = 1'b1;
            res.status = bsl_pkg::ST_NOTFOUND;
            state_next = S_IDLE;
          end else if (scan0 == elem_r) begin
            res_valid    = 1'b1;
            res.found_at = 5'(k + FW'(1));
            state_next   = S_IDLE;
          end else begin
            cmd.shift = 1'b1;
            k_next    = k + FW'(1);
          end
        end else begin
          // Walk to the requested position, then read it out
          if (k_x == CW'(pos_r) - CW'(1)) begin
            res_valid  = 1'b1;
            res.value  = scan0;
            state_next = S_IDLE;
            if (op_r == bsl_pkg::OP_DELETE) begin
              cmd.del   = 1'b1;
              fill_next = fill - FW'(1);
            end
          end else begin
            cmd.shift = 1'b1;
            k_next    = k + FW'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res.count    = 5'(fill_next);
    res.is_empty = (fill_next == '0);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      k     <= k_next;
    end
  end

  // Item held for the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op;
      pos_r  <= position;
      elem_r <= element;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(fill) <= CW'(CAPACITY))
    else $error("list length above capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (k <= fill))
    else $error("scan index beyond list length");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && res_valid) |=> (state == S_IDLE))
    else $error("scan continued after its result");
`endif

endmodule

`default_nettype wire

/* verif/tb_bounded_sequential_list.sv */
// Self-checking testbench for the bounded sequential list: random list operations vs a predictor.
`default_nettype none

module tb_bounded_sequential_list;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP          = 16;
  localparam int RANDOM_ITEMS = 1000;
  localparam int LONG_HOLD    = 160;         // receiver hold-off, long enough to back up the input
  localparam int IDLE_LIMIT   = 4000;        // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = CAP + 8;     // longest walk is a locate miss on a full list
  localparam int REPORT_MAX   = 10;

  // Op codes the block treats as no-ops
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} phase_e;

  // Tracks the list contents and holds the results still owed by the block
  class list_scoreboard;
    logic [7:0]    slots [CAP];
    int            fill;
    bsl_pkg::res_t owed_q [$];
    int            faults;

    function new();
      foreach (slots[i]) slots[i] = 8'h00;
      fill   = 0;
      faults = 0;
    endfunction

    function void fault(string msg);
      faults++;
      if (faults <= REPORT_MAX) $display("%0t ns: %s", $time, msg);
    endfunction

    function string show(bsl_pkg::res_t r);
      return $sformatf("status=%0d value=%02h found_at=%0d count=%0d is_empty=%0b",
                       r.status, r.value, r.found_at, r.count, r.is_empty);
    endfunction

    // Apply one accepted request to the list copy and queue the result it must give
    function void note_request(logic [2:0] op, logic [4:0] pos, logic [7:0] elem);
      bsl_pkg::res_t r;
      int            k;
      r        = '0;
      r.status = bsl_pkg::ST_OK;
      case (op)
        bsl_pkg::OP_GET: begin
          if (pos == 0 || pos > fill) r.status = bsl_pkg::ST_BADPOS;
          else r.value = slots[pos - 1];
        end
        bsl_pkg::OP_LOCATE: begin
          // first match wins
          for (k = 0; k < fill; k++) begin
            if (r.found_at == 0 && slots[k] == elem) r.found_at = 5'(k + 1);
          end
          if (r.found_at == 0) r.status = bsl_pkg::ST_NOTFOUND;
        end
        bsl_pkg::OP_INSERT: begin
          // position is checked before capacity
          if (pos == 0 || pos > fill + 1) begin
            r.status = bsl_pkg::ST_BADPOS;
          end else if (fill >= CAP) begin
            r.status = bsl_pkg::ST_FULL;
          end else begin
            for (k = fill; k >= pos; k--) slots[k] = slots[k - 1];
            slots[pos - 1] = elem;
            fill++;
          end
        end
        bsl_pkg::OP_DELETE: begin
          if (pos == 0 || pos > fill) begin
            r.status = bsl_pkg::ST_BADPOS;
          end else begin
            r.value = slots[pos - 1];
            for (k = pos - 1; k < fill - 1; k++) slots[k] = slots[k + 1];
            fill--;
          end
        end
        bsl_pkg::OP_CLEAR: fill = 0;   // slot contents stay
        default: ;                     // spare codes change nothing
      endcase
      r.count    = 5'(fill);
      r.is_empty = (fill == 0);
      owed_q.push_back(r);
    endfunction

    // Compare one accepted result with the oldest one owed
    function void check_result(bsl_pkg::res_t got);
      bsl_pkg::res_t want;
      if (owed_q.size() == 0) begin
        fault({"unexpected result: ", show(got)});
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status || got.value !== want.value ||
          got.found_at !== want.found_at || got.count !== want.count ||
          got.is_empty !== want.is_empty) begin
        fault({"mismatch: want ", show(want), " / got ", show(got)});
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  bsl_req_if req_ch ();
  bsl_rsp_if rsp_ch ();

  bounded_sequential_list #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  list_scoreboard sb;
  int             sent;
  int             burst_left;
  int             idle_cycles;
  bit             hold_req;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One request transfer; returns on the falling edge after acceptance
  task automatic send_req(input logic [2:0] op, input logic [4:0] pos,
                          input logic [7:0] elem);
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.position <= pos;
    req_ch.element  <= elem;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(op, pos, elem);
    sent++;
    @(negedge clk);
  endtask

  // Send in bursts with random gaps between them
  task automatic paced_send(input logic [2:0] op, input logic [4:0] pos,
                            input logic [7:0] elem, input int max_gap);
    int gap;
    send_req(op, pos, elem);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap        = $urandom_range(0, max_gap);
      if (gap > 0) begin
        // junk on the payload while idle
        req_ch.valid    <= 1'b0;
        req_ch.op       <= 3'($urandom);
        req_ch.position <= 5'($urandom);
        req_ch.element  <= 8'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Sender stops until every owed result has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_elem();
    // small alphabet half the time so locate meets duplicates
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 7));
    return 8'($urandom);
  endfunction

  // Grow the list to capacity, then try a few inserts into the full list
  task automatic fill_up(input int max_gap);
    while (sb.fill < CAP) begin
      paced_send(bsl_pkg::OP_INSERT, 5'($urandom_range(1, sb.fill + 1)), rand_elem(),
                 max_gap);
    end
    repeat (3) paced_send(bsl_pkg::OP_INSERT, 5'($urandom_range(1, CAP + 1)), rand_elem(),
                          max_gap);
  endtask

  // Random request shaped by the phase and the current list length
  task automatic pick_item(input phase_e kind, output logic [2:0] op,
                           output logic [4:0] pos, output logic [7:0] elem);
    int r;
    int len;
    r   = $urandom_range(0, 99);
    len = sb.fill;
    case (kind)
      PH_GROW: begin
        op = r < 60 ? bsl_pkg::OP_INSERT : r < 72 ? bsl_pkg::OP_GET :
             r < 84 ? bsl_pkg::OP_LOCATE : r < 95 ? bsl_pkg::OP_DELETE :
             r < 97 ? bsl_pkg::OP_CLEAR :
             3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      PH_SHRINK: begin
        op = r < 55 ? bsl_pkg::OP_DELETE : r < 70 ? bsl_pkg::OP_GET :
             r < 85 ? bsl_pkg::OP_LOCATE : r < 97 ? bsl_pkg::OP_INSERT :
             r < 98 ? bsl_pkg::OP_CLEAR :
             3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      default: begin
        op = r < 32 ? bsl_pkg::OP_INSERT : r < 57 ? bsl_pkg::OP_DELETE :
             r < 75 ? bsl_pkg::OP_GET : r < 94 ? bsl_pkg::OP_LOCATE :
             r < 96 ? bsl_pkg::OP_CLEAR :
             3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
    endcase
    // mostly legal positions, some anywhere in the field
    if ($urandom_range(0, 99) < 15) pos = 5'($urandom);
    else if (op == bsl_pkg::OP_INSERT) pos = 5'($urandom_range(1, len + 1));
    else if (len > 0) pos = 5'($urandom_range(1, len));
    else pos = 5'($urandom);
    // locate usually searches for something present
    if (op == bsl_pkg::OP_LOCATE && len > 0 && $urandom_range(0, 99) < 60)
      elem = sb.slots[$urandom_range(0, len - 1)];
    else
      elem = rand_elem();
  endtask

  // Edge cases: empty list, bad positions, front/end inserts, hit and miss, clear
  task automatic run_directed();
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) send_req(3'(c), 5'd31, 8'hFF);
    send_req(bsl_pkg::OP_GET,    5'd0,  8'h00);
    send_req(bsl_pkg::OP_GET,    5'd1,  8'h00);
    send_req(bsl_pkg::OP_DELETE, 5'd1,  8'h00);
    send_req(bsl_pkg::OP_INSERT, 5'd0,  8'h11);
    send_req(bsl_pkg::OP_INSERT, 5'd2,  8'h22);
    send_req(bsl_pkg::OP_LOCATE, 5'd0,  8'h00);
    send_req(bsl_pkg::OP_INSERT, 5'd1,  8'hFF);
    send_req(bsl_pkg::OP_INSERT, 5'd1,  8'h00);
    send_req(bsl_pkg::OP_INSERT, 5'd3,  8'hA5);
    send_req(bsl_pkg::OP_LOCATE, 5'd0,  8'hA5);
    send_req(bsl_pkg::OP_LOCATE, 5'd31, 8'h5A);
    send_req(bsl_pkg::OP_GET,    5'd3,  8'h00);
    send_req(bsl_pkg::OP_GET,    5'd4,  8'h00);
    send_req(bsl_pkg::OP_GET,    5'd31, 8'h00);
    send_req(bsl_pkg::OP_DELETE, 5'd2,  8'h00);
    send_req(bsl_pkg::OP_DELETE, 5'd0,  8'h00);
    send_req(bsl_pkg::OP_INSERT, 5'd31, 8'h77);
    send_req(bsl_pkg::OP_CLEAR,  5'd0,  8'h00);
    send_req(bsl_pkg::OP_GET,    5'd1,  8'h00);
    send_req(bsl_pkg::OP_INSERT, 5'd1,  8'h3C);
  endtask

  // Main stimulus
  initial begin : stimulus
    phase_e     kind;
    int         phase;
    int         len;
    int         max_gap;
    logic [2:0] op;
    logic [4:0] pos;
    logic [7:0] elem;

    sb              = new();
    sent            = 0;
    burst_left      = 0;
    hold_req        = 1'b0;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.op       = bsl_pkg::OP_GET;
    req_ch.position = 5'd0;
    req_ch.element  = 8'h00;
    rsp_ch.ready    = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();
    wait_drained();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      kind    = (phase == 0) ? PH_GROW : phase_e'($urandom_range(0, 2));
      len     = $urandom_range(20, 70);
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      // ask the receiver for its long hold-off while requests keep coming
      if (phase == 3) begin
        hold_req = 1'b1;
        max_gap  = 0;
      end
      if (kind == PH_GROW && (phase == 0 || $urandom_range(0, 2) == 0)) fill_up(max_gap);
      repeat (len) begin
        pick_item(kind, op, pos, elem);
        paced_send(op, pos, elem, max_gap);
      end
      if (phase == 2 || $urandom_range(0, 4) == 0) wait_drained();
      if ($urandom_range(0, 5) == 0) begin
        paced_send(bsl_pkg::OP_CLEAR, 5'($urandom), 8'($urandom), max_gap);
      end
      phase++;
    end
    req_ch.valid <= 1'b0;

    // wait out everything still owed, then allow for stray results
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.faults == 0 && sb.owed_q.size() == 0) begin
      $display("tb_bounded_sequential_list: done, clean");
    end else begin
      $display("tb_bounded_sequential_list: done, errors");
    end
    $finish;
  end

  // Result side back-pressure: mixed patterns plus one long hold-off on request
  initial begin : rsp_pacer
    int mode;
    int len;
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    n = 0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 80);
      repeat (len) begin
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= (n % 4 != 3);
        endcase
        n++;
        @(negedge clk);
      end
    end
  end

  // Result check on every accepted transfer
  always @(posedge clk) begin
    bsl_pkg::res_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status   = rsp_ch.status;
      got.value    = rsp_ch.value;
      got.found_at = rsp_ch.found_at;
      got.count    = rsp_ch.count;
      got.is_empty = rsp_ch.is_empty;
      sb.check_result(got);
    end
  end

  // Watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_bounded_sequential_list: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire
